FILE: rtl/mmcb_pkg.sv
// Package: types, codes and sizes shared by the multi-mode bank mapper.
package mmcb_pkg;

    localparam int PrgBanks8k = 32;
    localparam int ChrBanks1k = 512;

    typedef enum logic [2:0] {
        OP_LOW_WRITE  = 3'd0,
        OP_CART_WRITE = 3'd1,
        OP_SCANLINE   = 3'd2,
        OP_CPU_FETCH  = 3'd3,
        OP_PPU_FETCH  = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [8:0]  scanline_number;
        logic        display_enabled;
    } t_in_word;

    typedef struct packed {
        logic [18:0] rom_offset;
        logic        offset_valid;
        logic [1:0]  mirroring;
        logic        irq_line;
    } t_out_word;

    // Fetch request from the state unit to the translator.
    typedef struct packed {
        logic        cpu;
        logic        ppu;
        logic [15:0] address;
    } t_fetch;

    // Register view the translator needs.
    typedef struct packed {
        logic [7:0]      mode;
        logic [7:0][7:0] vrc_chr;
        logic [1:0][7:0] vrc_prg;
        logic [7:0][7:0] mmc3_bank;
        logic [7:0]      mmc3_select;
        logic [4:0]      mmc1_r0;
        logic [4:0]      mmc1_r1;
        logic [4:0]      mmc1_r2;
        logic [4:0]      mmc1_r3;
    } t_bank_view;

endpackage

FILE: rtl/multi_mode_cartridge_bank_mapper.sv
// Top level of the multi-mode cartridge bank mapper.
// One word in, one word out. An input word is held in the input register, then
// translated and applied to the mapper registers by a single pass of logic when
// it advances; the result word is held in an output register. Throughput is one
// word per cycle while the output is not stalled, and the result word is loaded
// into the output register when the input stage advances.
// Input stalls only while the output register is full, stalled, and the input
// stage also holds a word.
module multi_mode_cartridge_bank_mapper (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  mmcb_pkg::t_in_word    i_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output mmcb_pkg::t_out_word   o_word
);
    logic                 r_in_valid;
    mmcb_pkg::t_in_word   r_in;
    logic                 adv;
    mmcb_pkg::t_bank_view view;
    mmcb_pkg::t_fetch     fetch;
    logic [1:0]           mir;
    logic                 irq;
    logic [18:0]          off;
    logic                 offv;

    // Advance the input stage when the output register can take a word.
    assign adv     = r_in_valid && (!o_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;

    // Hold the accepted input word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_word;
        end
    end

    mmcb_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_word(r_in),
        .o_view(view), .o_mirroring(mir), .o_irq(irq)
    );

    assign fetch.cpu     = r_in.operation == mmcb_pkg::OP_CPU_FETCH;
    assign fetch.ppu     = r_in.operation == mmcb_pkg::OP_PPU_FETCH;
    assign fetch.address = r_in.address;

    mmcb_translate u_xlat (
        .i_fetch(fetch), .i_view(view), .o_offset(off), .o_valid(offv)
    );

    // Load the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_word.rom_offset   <= off;
            o_word.offset_valid <= offv;
            o_word.mirroring    <= mir;
            o_word.irq_line     <= irq;
        end
    end
endmodule

FILE: rtl/mmcb_translate.sv
// Combinational fetch translation from bank registers to a ROM byte offset.
module mmcb_translate (
    input  mmcb_pkg::t_fetch     i_fetch,
    input  mmcb_pkg::t_bank_view i_view,
    output logic [18:0]          o_offset,
    output logic                 o_valid
);
    localparam int PrgW = $clog2(mmcb_pkg::PrgBanks8k);
    localparam int ChrW = $clog2(mmcb_pkg::ChrBanks1k);

    logic [1:0]  m;
    logic [1:0]  pslot;
    logic [2:0]  cslot;
    logic [2:0]  s3;
    logic [7:0]  prg;
    logic [9:0]  chr;
    logic [9:0]  base;
    logic [3:0]  bank16;
    logic [4:0]  b16;
    logic [4:0]  b4;
    logic [31:0] poff;
    logic [31:0] coff;

    assign m     = i_view.mode[1:0];
    assign pslot = i_fetch.address[14:13];
    assign cslot = i_fetch.address[12:10];
    assign base  = {1'b0, i_view.mode[2], 8'd0};
    assign bank16 = i_view.mmc1_r3[3:0];

    // Pick the 8 KiB PRG bank.
    always_comb begin
        b16 = 5'd0;
        prg = 8'd0;
        if (m == 2'd0) begin
            if (!pslot[1]) prg = i_view.vrc_prg[pslot[0]];
            else prg = pslot[0] ? 8'h1F : 8'h1E;
        end else if (m == 2'd1) begin
            unique case (pslot)
                2'd0: prg = i_view.mmc3_select[6] ? 8'hFE : i_view.mmc3_bank[6];
                2'd1: prg = i_view.mmc3_bank[7];
                2'd2: prg = i_view.mmc3_select[6] ? i_view.mmc3_bank[6] : 8'hFE;
                default: prg = 8'hFF;
            endcase
        end else if (i_view.mmc1_r0[3]) begin
            if (i_view.mmc1_r0[2]) b16 = pslot[1] ? 5'h0F : {1'b0, bank16};
            else b16 = pslot[1] ? {1'b0, bank16} : 5'd0;
            prg = {2'b00, b16, pslot[0]};
        end else begin
            prg = {3'b000, bank16[3:1], pslot};
        end
    end

    // Pick the 1 KiB CHR bank.
    always_comb begin
        s3 = cslot ^ {i_view.mmc3_select[7], 2'b00};
        b4 = cslot[2] ? i_view.mmc1_r2 : i_view.mmc1_r1;
        chr = 10'd0;
        if (m == 2'd0) begin
            chr = base | {2'b00, i_view.vrc_chr[cslot]};
        end else if (m == 2'd1) begin
            if (!s3[2]) chr = {(base[9:1] | {1'b0, i_view.mmc3_bank[{2'b00, s3[1]}]}), s3[0]};
            else chr = base | {2'b00, i_view.mmc3_bank[{1'b0, s3[1:0]} + 3'd2]};
        end else if (i_view.mmc1_r0[4]) begin
            chr = {3'b000, b4, cslot[1:0]};
        end else begin
            chr = {3'b000, i_view.mmc1_r1[4:1], cslot};
        end
    end

    // Form the byte offset, wrapping the bank at the ROM size.
    always_comb begin
        poff = {{(32-PrgW-13){1'b0}}, prg[PrgW-1:0], i_fetch.address[12:0]};
        coff = {{(32-ChrW-10){1'b0}}, chr[ChrW-1:0], i_fetch.address[9:0]};
        o_valid  = 1'b0;
        o_offset = 19'd0;
        if (i_fetch.cpu && i_fetch.address[15]) begin
            o_valid = 1'b1;
            o_offset = poff[18:0];
        end else if (i_fetch.ppu && i_fetch.address[15:13] == 3'd0) begin
            o_valid = 1'b1;
            o_offset = coff[18:0];
        end
    end
endmodule

FILE: rtl/mmcb_regs.sv
// Mapper register file: mode, bank registers, serial port and scanline counter.
module mmcb_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  mmcb_pkg::t_in_word   i_word,
    output mmcb_pkg::t_bank_view o_view,
    output logic [1:0]           o_mirroring,
    output logic                 o_irq
);
    logic [7:0]       r_mode, n_mode;
    logic [7:0][7:0]  r_vchr, n_vchr;
    logic [1:0][7:0]  r_vprg, n_vprg;
    logic             r_vmir, n_vmir;
    logic [7:0][7:0]  r_mbank, n_mbank;
    logic [7:0]       r_msel, n_msel;
    logic             r_mmir, n_mmir;
    logic signed [15:0] r_cnt, n_cnt;
    logic [7:0]       r_reload, n_reload;
    logic             r_irq_en, n_irq_en;
    logic             r_pend, n_pend;
    logic [3:0][4:0]  r_s, n_s;
    logic [4:0]       r_sbuf, n_sbuf;
    logic [2:0]       r_scnt, n_scnt;

    logic [15:0] a;
    logic [7:0]  d;
    logic [2:0]  ind;
    logic [2:0]  cnt;
    logic [4:0]  sb;

    assign a = i_word.address;
    assign d = i_word.write_data;

    // Work out next register state for the item.
    always_comb begin
        n_mode = r_mode; n_vchr = r_vchr; n_vprg = r_vprg; n_vmir = r_vmir;
        n_mbank = r_mbank; n_msel = r_msel; n_mmir = r_mmir; n_cnt = r_cnt;
        n_reload = r_reload; n_irq_en = r_irq_en; n_pend = r_pend;
        n_s = r_s; n_sbuf = r_sbuf; n_scnt = r_scnt;
        ind = {a[13], a[12], a[11] | a[1]} + 3'd2;
        cnt = (r_scnt > 3'd4) ? 3'd0 : r_scnt;
        sb  = (r_sbuf | ({4'd0, d[0]} << cnt));
        if (i_en) begin
            unique case (i_word.operation)
                mmcb_pkg::OP_LOW_WRITE: begin
                    if ((a & 16'h4100) == 16'h4100) begin
                        n_mode = d;
                        if (a[0]) begin
                            n_s[0] = 5'h0C; n_s[3] = 5'd0; n_sbuf = 5'd0; n_scnt = 3'd0;
                        end
                    end
                end
                mmcb_pkg::OP_CART_WRITE: begin
                    if (r_mode[1:0] == 2'd0) begin
                        if (a >= 16'hB000 && a <= 16'hE003) begin
                            if (a[0]) n_vchr[ind] = {d[3:0], r_vchr[ind][3:0]};
                            else n_vchr[ind] = {r_vchr[ind][7:4], d[3:0]};
                        end else begin
                            unique case (a[15:12])
                                4'h8: n_vprg[0] = d;
                                4'hA: n_vprg[1] = d;
                                4'h9: n_vmir = d[0];
                                default: ;
                            endcase
                        end
                    end else if (r_mode[1:0] == 2'd1) begin
                        unique case (a & 16'hE001)
                            16'h8000: n_msel = d;
                            16'h8001: n_mbank[r_msel[2:0]] =
                                (r_msel[2:1] == 2'd0) ? {1'b0, d[7:1]} : d;
                            16'hA000: n_mmir = d[0];
                            16'hC000: n_cnt = {8'd0, d};
                            16'hC001: n_reload = d;
                            16'hE000: begin
                                n_cnt = {8'd0, r_reload}; n_irq_en = 1'b0; n_pend = 1'b0;
                            end
                            16'hE001: n_irq_en = 1'b1;
                            default: ;
                        endcase
                    end else if (d[7]) begin
                        n_s[0] = r_s[0] | 5'h0C; n_sbuf = 5'd0; n_scnt = 3'd0;
                    end else if (cnt == 3'd4) begin
                        n_s[a[14:13]] = sb; n_sbuf = 5'd0; n_scnt = 3'd0;
                    end else begin
                        n_sbuf = sb; n_scnt = cnt + 3'd1;
                    end
                end
                mmcb_pkg::OP_SCANLINE: begin
                    if (i_word.scanline_number <= 9'd239) begin
                        if (r_cnt <= 16'sd0 && r_irq_en) n_pend = 1'b1;
                        else if (i_word.display_enabled && r_cnt != 16'sh8000)
                            n_cnt = r_cnt - 16'sd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold state; load reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0; r_vmir <= 1'b0; r_msel <= '0; r_mmir <= 1'b0;
            for (int i = 0; i < 8; i++) r_vchr[i] <= 8'(i);
            r_vprg[0] <= 8'd0; r_vprg[1] <= 8'd1;
            r_mbank <= {8'h3D, 8'h3C, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};
            r_cnt <= '0; r_reload <= '0; r_irq_en <= 1'b0; r_pend <= 1'b0;
            r_s <= {5'd0, 5'd0, 5'd0, 5'h0C}; r_sbuf <= '0; r_scnt <= '0;
        end else begin
            r_mode <= n_mode; r_vchr <= n_vchr; r_vprg <= n_vprg; r_vmir <= n_vmir;
            r_mbank <= n_mbank; r_msel <= n_msel; r_mmir <= n_mmir; r_cnt <= n_cnt;
            r_reload <= n_reload; r_irq_en <= n_irq_en; r_pend <= n_pend;
            r_s <= n_s; r_sbuf <= n_sbuf; r_scnt <= n_scnt;
        end
    end

    // Report the state after this item.
    always_comb begin
        o_view.mode = n_mode; o_view.vrc_chr = n_vchr; o_view.vrc_prg = n_vprg;
        o_view.mmc3_bank = n_mbank; o_view.mmc3_select = n_msel;
        o_view.mmc1_r0 = n_s[0]; o_view.mmc1_r1 = n_s[1];
        o_view.mmc1_r2 = n_s[2]; o_view.mmc1_r3 = n_s[3];
        o_irq = n_pend;
        if (n_mode[1:0] == 2'd0) o_mirroring = {1'b0, n_vmir};
        else if (n_mode[1:0] == 2'd1) o_mirroring = {1'b0, n_mmir};
        else begin
            unique case (n_s[0][1:0])
                2'd0: o_mirroring = 2'd2;
                2'd1: o_mirroring = 2'd3;
                2'd2: o_mirroring = 2'd0;
                default: o_mirroring = 2'd1;
            endcase
        end
    end
endmodule

FILE: rtl/mmcb_checker.sv
// Port checker for the bank mapper, bound to the top level.
module mmcb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input mmcb_pkg::t_out_word o_word
);
    // Offset is zero whenever it is not a translated fetch.
    a_zero_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.offset_valid) |-> o_word.rom_offset == 19'd0)
        else $error("offset not zero on non-fetch word");

    // Stall input only when the output side is backed up.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output backpressure");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_word)))
        else $error("stalled output word changed");

    // An accepted word shows up at the output when nothing stalls.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall |=> o_valid)
        else $error("word lost in pipeline");
endmodule

bind multi_mode_cartridge_bank_mapper mmcb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the multi-mode cartridge bank mapper.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    mmcb_pkg::t_in_word  i_word;
    logic                o_valid;
    logic                i_stall;
    mmcb_pkg::t_out_word o_word;

    multi_mode_cartridge_bank_mapper dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_word(i_word), .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word)
    );

    localparam int WatchdogLimit = 2000;

    // Mapper state mirror
    logic [7:0]      mode_reg;
    logic [7:0][7:0] vrc_chr;
    logic [1:0][7:0] vrc_prg;
    logic            vrc_mirror;
    logic [7:0][7:0] mmc3_bank;
    logic [7:0]      mmc3_select;
    logic            mmc3_mirror;
    logic signed [15:0] irq_cnt;
    logic [7:0]      irq_reload;
    logic            irq_en;
    logic            irq_pend;
    logic [3:0][4:0] mmc1_reg;
    logic [4:0]      shift_buf;
    logic [2:0]      shift_cnt;

    mmcb_pkg::t_out_word expected_words[$];
    int        error_count;
    int        idle_cycles;
    int        rx_wait;

    // Clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic void mapper_reset();
        mode_reg    = '0;
        for (int i = 0; i < 8; i++) vrc_chr[i] = 8'(i);
        vrc_prg[0]  = 8'd0;
        vrc_prg[1]  = 8'd1;
        vrc_mirror  = 1'b0;
        mmc3_bank   = {8'h3D, 8'h3C, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};
        mmc3_select = '0;
        mmc3_mirror = 1'b0;
        irq_cnt     = '0;
        irq_reload  = '0;
        irq_en      = 1'b0;
        irq_pend    = 1'b0;
        mmc1_reg    = {5'd0, 5'd0, 5'd0, 5'h0C};
        shift_buf   = '0;
        shift_cnt   = '0;
    endfunction

    function automatic void serial_clear();
        mmc1_reg[0] = 5'h0C;
        mmc1_reg[3] = 5'd0;
        shift_buf   = '0;
        shift_cnt   = '0;
    endfunction

    function automatic logic [1:0] mirror_now();
        if (mode_reg[1:0] == 2'd0) return {1'b0, vrc_mirror};
        if (mode_reg[1:0] == 2'd1) return {1'b0, mmc3_mirror};
        case (mmc1_reg[0][1:0])
            2'd0: return 2'd2;
            2'd1: return 2'd3;
            2'd2: return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    function automatic int unsigned prg_bank(int unsigned slot);
        int unsigned bank;
        int unsigned b16;
        if (mode_reg[1:0] == 2'd0) begin
            if (slot < 2) return vrc_prg[slot];
            return slot == 2 ? 32'h1E : 32'h1F;
        end
        if (mode_reg[1:0] == 2'd1) begin
            case (slot)
                0: return mmc3_select[6] ? 32'hFE : mmc3_bank[6];
                1: return mmc3_bank[7];
                2: return mmc3_select[6] ? mmc3_bank[6] : 32'hFE;
                default: return 32'hFF;
            endcase
        end
        bank = mmc1_reg[3][3:0];
        if (mmc1_reg[0][3]) begin
            if (mmc1_reg[0][2]) b16 = (slot >> 1) ? 32'h0F : bank;
            else b16 = (slot >> 1) ? bank : 0;
            return b16 * 2 + (slot & 1);
        end
        return (bank >> 1) * 4 + slot;
    endfunction

    function automatic int unsigned chr_bank(int unsigned slot);
        int unsigned base;
        int unsigned s;
        int unsigned b4;
        base = mode_reg[2] ? 256 : 0;
        if (mode_reg[1:0] == 2'd0) return base | vrc_chr[slot];
        if (mode_reg[1:0] == 2'd1) begin
            s = slot;
            if (mmc3_select[7]) s = s ^ 4;
            if (s < 4) return ((base >> 1) | mmc3_bank[s >> 1]) * 2 + (s & 1);
            return base | mmc3_bank[s - 2];
        end
        if (mmc1_reg[0][4]) begin
            b4 = (slot < 4) ? mmc1_reg[1] : mmc1_reg[2];
            return b4 * 4 + (slot & 3);
        end
        return (mmc1_reg[1] >> 1) * 8 + slot;
    endfunction

    function automatic void cart_write(logic [15:0] addr, logic [7:0] data);
        int unsigned ind;
        int unsigned sh;
        int unsigned cnt;
        logic [7:0]  v;
        if (mode_reg[1:0] == 2'd0) begin
            if (addr >= 16'hB000 && addr <= 16'hE003) begin
                ind = ((((addr & 2) | (addr >> 10)) >> 1) + 2) & 7;
                sh  = addr[0] ? 4 : 0;
                v   = (vrc_chr[ind] & (8'hF0 >> sh)) | ({4'd0, data[3:0]} << sh);
                vrc_chr[ind] = v;
            end else begin
                case (addr[15:12])
                    4'h8: vrc_prg[0] = data;
                    4'hA: vrc_prg[1] = data;
                    4'h9: vrc_mirror = data[0];
                    default: ;
                endcase
            end
        end else if (mode_reg[1:0] == 2'd1) begin
            case (addr & 16'hE001)
                16'h8000: mmc3_select = data;
                16'h8001: mmc3_bank[mmc3_select[2:0]] =
                    (mmc3_select[2:0] < 2) ? (data >> 1) : data;
                16'hA000: mmc3_mirror = data[0];
                16'hC000: irq_cnt = {8'd0, data};
                16'hC001: irq_reload = data;
                16'hE000: begin
                    irq_cnt  = {8'd0, irq_reload};
                    irq_en   = 1'b0;
                    irq_pend = 1'b0;
                end
                16'hE001: irq_en = 1'b1;
                default: ;
            endcase
        end else if (data[7]) begin
            mmc1_reg[0] = mmc1_reg[0] | 5'h0C;
            shift_buf   = '0;
            shift_cnt   = '0;
        end else begin
            cnt = shift_cnt;
            if (cnt > 4) cnt = 0;
            shift_buf = shift_buf | (5'(data[0]) << cnt);
            cnt++;
            if (cnt == 5) begin
                mmc1_reg[addr[14:13]] = shift_buf;
                shift_buf = '0;
                cnt = 0;
            end
            shift_cnt = 3'(cnt);
        end
    endfunction

    // Apply one word to the mirror and return the result it should produce
    function automatic mmcb_pkg::t_out_word mapper_step(mmcb_pkg::t_in_word w);
        mmcb_pkg::t_out_word r;
        int unsigned b;
        r = '0;
        case (w.operation)
            mmcb_pkg::OP_LOW_WRITE: begin
                if ((w.address & 16'h4100) == 16'h4100) begin
                    mode_reg = w.write_data;
                    if (w.address[0]) serial_clear();
                end
            end
            mmcb_pkg::OP_CART_WRITE: cart_write(w.address, w.write_data);
            mmcb_pkg::OP_SCANLINE: begin
                if (w.scanline_number <= 239) begin
                    if (irq_cnt <= 0 && irq_en) irq_pend = 1'b1;
                    else if (w.display_enabled && irq_cnt != 16'sh8000)
                        irq_cnt = irq_cnt - 16'sd1;
                end
            end
            mmcb_pkg::OP_CPU_FETCH: begin
                if (w.address >= 16'h8000) begin
                    b = prg_bank(w.address[14:13]) % mmcb_pkg::PrgBanks8k;
                    r.rom_offset   = 19'(b * 8192 + w.address[12:0]);
                    r.offset_valid = 1'b1;
                end
            end
            mmcb_pkg::OP_PPU_FETCH: begin
                if (w.address < 16'h2000) begin
                    b = chr_bank(w.address[12:10]) % mmcb_pkg::ChrBanks1k;
                    r.rom_offset   = 19'(b * 1024 + w.address[9:0]);
                    r.offset_valid = 1'b1;
                end
            end
            default: ;
        endcase
        r.mirroring = mirror_now();
        r.irq_line  = irq_pend;
        return r;
    endfunction

    // Send one word after a random gap, predict its result on acceptance
    task automatic send_word(mmcb_pkg::t_in_word w);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_words.push_back(mapper_step(w));
    endtask

    task automatic send_op(mmcb_pkg::t_op op, logic [15:0] addr, logic [7:0] data);
        mmcb_pkg::t_in_word w;
        w.operation       = op;
        w.address         = addr;
        w.write_data      = data;
        w.scanline_number = 9'($urandom_range(0, 511));
        w.display_enabled = 1'($urandom);
        send_word(w);
    endtask

    task automatic send_tick(logic [8:0] line, logic disp);
        mmcb_pkg::t_in_word w;
        w.operation       = mmcb_pkg::OP_SCANLINE;
        w.address         = 16'($urandom);
        w.write_data      = 8'($urandom);
        w.scanline_number = line;
        w.display_enabled = disp;
        send_word(w);
    endtask

    task automatic send_fetches(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1))
                send_op(mmcb_pkg::OP_CPU_FETCH, 16'($urandom), 8'($urandom));
            else
                send_op(mmcb_pkg::OP_PPU_FETCH, 16'($urandom_range(0, 16'h3FFF)),
                        8'($urandom));
        end
    endtask

    // Extremes, unknown codes and untranslated fetches
    task automatic test_directed();
        mmcb_pkg::t_in_word w;
        send_op(mmcb_pkg::OP_CPU_FETCH, 16'hFFFF, 8'h00);
        send_op(mmcb_pkg::OP_CPU_FETCH, 16'h8000, 8'hFF);
        send_op(mmcb_pkg::OP_CPU_FETCH, 16'h7FFF, 8'h00);
        send_op(mmcb_pkg::OP_PPU_FETCH, 16'h0000, 8'h00);
        send_op(mmcb_pkg::OP_PPU_FETCH, 16'h1FFF, 8'h00);
        send_op(mmcb_pkg::OP_PPU_FETCH, 16'h2000, 8'h00);
        send_op(mmcb_pkg::OP_LOW_WRITE, 16'h4000, 8'h01);
        send_op(mmcb_pkg::OP_LOW_WRITE, 16'hFFFF, 8'h05);
        send_fetches(3);
        send_op(mmcb_pkg::OP_LOW_WRITE, 16'h4100, 8'h00);
        for (int c = 5; c < 8; c++) begin
            w.operation       = 3'(c);
            w.address         = 16'($urandom);
            w.write_data      = 8'($urandom);
            w.scanline_number = 9'($urandom);
            w.display_enabled = 1'($urandom);
            send_word(w);
        end
        send_tick(9'd239, 1'b1);
        send_tick(9'd240, 1'b1);
        send_tick(9'd511, 1'b0);
        send_tick(9'd0, 1'b0);
    endtask

    // VRC2-like mode: PRG, mirroring and nibble CHR writes
    task automatic test_vrc_mode(int n);
        logic [15:0] a;
        send_op(mmcb_pkg::OP_LOW_WRITE, 16'h4100, 8'($urandom) & 8'hFC);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: a = 16'hB000 + 16'($urandom_range(0, 16'h3003));
                1: a = {4'(8 + $urandom_range(0, 2)), 12'($urandom)};
                2: a = 16'($urandom);
                default: a = {2'b10, 14'($urandom)} | 16'h3000;
            endcase
            if ($urandom_range(0, 1)) send_op(mmcb_pkg::OP_CART_WRITE, a, 8'($urandom));
            else send_fetches(1);
        end
    endtask

    // MMC3-like mode: bank select and data pairs, IRQ counter
    task automatic test_mmc3_mode(int n);
        logic [15:0] a;
        send_op(mmcb_pkg::OP_LOW_WRITE, 16'h4100 | 16'($urandom_range(0, 1)),
                (8'($urandom) & 8'hFC) | 8'h01);
        for (int i = 0; i < n; i++) begin
            a = {3'($urandom_range(4, 7)), 12'($urandom), 1'($urandom)};
            case ($urandom_range(0, 5))
                0: begin
                    send_op(mmcb_pkg::OP_CART_WRITE, a & 16'hFFFE | 16'h8000 & 16'h9FFF,
                            8'($urandom));
                    send_op(mmcb_pkg::OP_CART_WRITE, (a | 16'h0001) & 16'h9FFF | 16'h8000,
                            8'($urandom));
                end
                1: send_op(mmcb_pkg::OP_CART_WRITE, a, 8'($urandom));
                2: send_tick(9'($urandom_range(0, 261)), 1'($urandom_range(0, 3) != 0));
                3: send_op(mmcb_pkg::OP_CART_WRITE, 16'hE001, 8'($urandom));
                4: send_op(mmcb_pkg::OP_CART_WRITE, 16'hC000 | 16'($urandom_range(0, 1)),
                           8'($urandom_range(0, 4)));
                default: send_fetches(2);
            endcase
        end
    endtask

    // Counter runs down past zero, then raises and clears the IRQ
    task automatic test_counter_floor();
        send_op(mmcb_pkg::OP_LOW_WRITE, 16'h4100, 8'h01);
        send_op(mmcb_pkg::OP_CART_WRITE, 16'hE000, 8'h00);
        send_op(mmcb_pkg::OP_CART_WRITE, 16'hC000, 8'h00);
        for (int i = 0; i < 40; i++) begin
            mmcb_pkg::t_in_word w;
            w = '0;
            w.operation = mmcb_pkg::OP_SCANLINE;
            w.scanline_number = 9'd10;
            w.display_enabled = 1'b1;
            i_valid <= 1'b1;
            i_word  <= w;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            expected_words.push_back(mapper_step(w));
        end
        send_op(mmcb_pkg::OP_CART_WRITE, 16'hE001, 8'h00);
        send_tick(9'd5, 1'b1);
        send_op(mmcb_pkg::OP_CART_WRITE, 16'hE000, 8'h00);
    endtask

    // MMC1-like modes: five-write serial sequences, resets and noise
    task automatic test_serial_mode(int n);
        send_op(mmcb_pkg::OP_LOW_WRITE, 16'h4101 | 16'($urandom) & 16'hBEFE,
                (8'($urandom) & 8'hFC) | 8'($urandom_range(2, 3)));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: send_op(mmcb_pkg::OP_CART_WRITE, 16'($urandom), 8'($urandom) | 8'h80);
                1: send_op(mmcb_pkg::OP_LOW_WRITE, 16'h4101, mode_reg);
                2: send_op(mmcb_pkg::OP_CART_WRITE, 16'($urandom), 8'($urandom) & 8'h7F);
                3, 4: send_fetches(2);
                default: begin
                    logic [15:0] a;
                    a = 16'($urandom);
                    for (int k = 0; k < 5; k++)
                        send_op(mmcb_pkg::OP_CART_WRITE, a, 8'($urandom) & 8'h7F);
                end
            endcase
        end
    endtask

    // Fully random words across modes
    task automatic test_random_mix(int n);
        mmcb_pkg::t_in_word w;
        for (int i = 0; i < n; i++) begin
            w.operation       = 3'($urandom);
            w.address         = 16'($urandom);
            w.write_data      = 8'($urandom);
            w.scanline_number = 9'($urandom);
            w.display_enabled = 1'($urandom);
            if ($urandom_range(0, 7) == 0) w.address = w.address | 16'h4100;
            send_word(w);
        end
    endtask

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        mmcb_pkg::t_out_word exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected output word %h", o_word);
                error_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_word.rom_offset !== exp_w.rom_offset) begin
                    $error("rom_offset exp %h got %h", exp_w.rom_offset, o_word.rom_offset);
                    error_count++;
                end
                if (o_word.offset_valid !== exp_w.offset_valid) begin
                    $error("offset_valid exp %b got %b", exp_w.offset_valid,
                           o_word.offset_valid);
                    error_count++;
                end
                if (o_word.mirroring !== exp_w.mirroring) begin
                    $error("mirroring exp %d got %d", exp_w.mirroring, o_word.mirroring);
                    error_count++;
                end
                if (o_word.irq_line !== exp_w.irq_line) begin
                    $error("irq_line exp %b got %b", exp_w.irq_line, o_word.irq_line);
                    error_count++;
                end
            end
        end
    end

    // Stall the output for a drawn number of cycles before each word
    always @(posedge i_clk) begin
        if (o_valid && !i_stall)
            rx_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        else if (o_valid && rx_wait > 0)
            rx_wait = rx_wait - 1;
        i_stall <= (rx_wait > 0);
    end

    // Watchdog: count cycles where nothing moves
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cycles <= 0;
        else if (expected_words.size() != 0 || i_valid) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_word          = '0;
        i_stall         = 1'b0;
        error_count     = 0;
        idle_cycles     = 0;
        mapper_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_vrc_mode(150);
        test_mmc3_mode(120);
        test_serial_mode(80);
        test_vrc_mode(60);
        test_mmc3_mode(60);
        test_random_mix(100);
        test_counter_floor();
        test_serial_mode(25);
        i_valid <= 1'b0;
        wait (expected_words.size() == 0);
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
